@@ src/crg_pkg.sv @@
// Shared types, constants and helpers for the preset color ramp generator.
`timescale 1ns / 1ps
`default_nettype none
package crg_pkg;

    localparam int PRESET_W         = 5;
    localparam int PRESET_RESET     = 18;
    localparam int SIZE_RESET       = 256;
    localparam int DEF_INDEX_BITS   = 16;
    localparam int DEF_CHANNEL_BITS = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int CFG_IDX_W        = 1;
    localparam int HUE_QBITS        = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRESET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 1'b1;

    // Preset codes
    localparam logic [PRESET_W-1:0] PR_RED_TO_BLUE     = 5'd0;
    localparam logic [PRESET_W-1:0] PR_BLUE_TO_RED     = 5'd1;
    localparam logic [PRESET_W-1:0] PR_YELLOW_TO_CYAN  = 5'd2;
    localparam logic [PRESET_W-1:0] PR_CYAN_TO_YELLOW  = 5'd3;
    localparam logic [PRESET_W-1:0] PR_RED_TO_YELLOW   = 5'd4;
    localparam logic [PRESET_W-1:0] PR_YELLOW_TO_RED   = 5'd5;
    localparam logic [PRESET_W-1:0] PR_YELLOW_TO_GREEN = 5'd6;
    localparam logic [PRESET_W-1:0] PR_GREEN_TO_YELLOW = 5'd7;
    localparam logic [PRESET_W-1:0] PR_GREEN_TO_CYAN   = 5'd8;
    localparam logic [PRESET_W-1:0] PR_CYAN_TO_GREEN   = 5'd9;
    localparam logic [PRESET_W-1:0] PR_CYAN_TO_BLUE    = 5'd10;
    localparam logic [PRESET_W-1:0] PR_BLUE_TO_CYAN    = 5'd11;
    localparam logic [PRESET_W-1:0] PR_RED             = 5'd12;
    localparam logic [PRESET_W-1:0] PR_RED_INV         = 5'd13;
    localparam logic [PRESET_W-1:0] PR_GREEN           = 5'd14;
    localparam logic [PRESET_W-1:0] PR_GREEN_INV       = 5'd15;
    localparam logic [PRESET_W-1:0] PR_BLUE            = 5'd16;
    localparam logic [PRESET_W-1:0] PR_BLUE_INV        = 5'd17;
    localparam logic [PRESET_W-1:0] PR_HSV             = 5'd18;

    // Where each output channel takes its level from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_FULL,
        SRC_UP,
        SRC_DN
    } t_src;

    typedef struct packed {
        t_src red;
        t_src green;
        t_src blue;
    } t_map;

    typedef struct packed {
        logic invalid;
        t_map map;
    } t_job_ctl;

    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5,
        SEC_WRAP,
        SEC_NONE
    } t_sector;

    function automatic int size_width(int ib);
        return (ib > 9) ? ib : 9;
    endfunction

    // Numerators and denominators reach ten times the palette size
    function automatic int arg_width(int ib);
        return size_width(ib) + 4;
    endfunction

    function automatic int cfg_width(int ib);
        return (ib > PRESET_W) ? ib : PRESET_W;
    endfunction

    function automatic t_map hue_map(logic [HUE_QBITS-1:0] q);
        t_map m;
        m = '{SRC_FULL, SRC_UP, SRC_ZERO};
        case (t_sector'(q))
            SEC_0, SEC_WRAP: m = '{SRC_FULL, SRC_UP, SRC_ZERO};
            SEC_1:           m = '{SRC_DN, SRC_FULL, SRC_ZERO};
            SEC_2:           m = '{SRC_ZERO, SRC_FULL, SRC_UP};
            SEC_3:           m = '{SRC_ZERO, SRC_DN, SRC_FULL};
            SEC_4:           m = '{SRC_UP, SRC_ZERO, SRC_FULL};
            SEC_5:           m = '{SRC_FULL, SRC_ZERO, SRC_DN};
            default:         m = '{SRC_ZERO, SRC_ZERO, SRC_ZERO};
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ src/crg_index_if.sv @@
// Palette index stream channel.
`timescale 1ns / 1ps
`default_nettype none
interface crg_index_if
    import crg_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] entry_index;

    modport source (output valid, output entry_index, input ready);
    modport sink   (input valid, input entry_index, output ready);
endinterface
`default_nettype wire

@@ src/crg_color_if.sv @@
// Color result stream channel.
`timescale 1ns / 1ps
`default_nettype none
interface crg_color_if
    import crg_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_level;
    logic [CHANNEL_BITS-1:0] green_level;
    logic [CHANNEL_BITS-1:0] blue_level;
    logic                    invalid_request;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, output invalid_request, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, input invalid_request, output ready);
endinterface
`default_nettype wire

@@ src/preset_color_ramp_generator.sv @@
// Top level of the preset color ramp generator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one palette index per clock and returns the RGB color of that entry for
// the configured preset and palette size, one result per clock when the output
// side keeps taking them. The path runs through an input register, three
// hue-sector divide stages, a four-entry queue, a divider load stage, one
// rounding-divider stage per channel bit and the output register. The rounding
// divider retires one quotient bit per stage. Write the preset (index 0) and
// palette size (index 1) only while no transactions are in flight; a size below
// 2 acts as 256. Out-of-range indexes and unknown presets return black with
// invalid_request set.
module preset_color_ramp_generator
    import crg_pkg::*;
#(
    parameter int INDEX_BITS   = DEF_INDEX_BITS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  wire logic [cfg_width(INDEX_BITS)-1:0]  i_cfg_data,
    crg_index_if.sink                              i_pix,
    crg_color_if.source                            o_col
);

    localparam int AW = arg_width(INDEX_BITS);

    logic          push, full, q_valid, pop;
    logic [AW-1:0] f_a, f_den, q_a, q_den;
    t_job_ctl      f_ctl, q_ctl;

    crg_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_pix.valid),
        .o_ready     (i_pix.ready),
        .i_index     (i_pix.entry_index),
        .o_push      (push),
        .i_full      (full),
        .o_a         (f_a),
        .o_den       (f_den),
        .o_ctl       (f_ctl)
    );

    crg_queue #(
        .INDEX_BITS (INDEX_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_a     (f_a),
        .i_den   (f_den),
        .i_ctl   (f_ctl),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_a     (q_a),
        .o_den   (q_den),
        .o_ctl   (q_ctl)
    );

    crg_back #(
        .INDEX_BITS   (INDEX_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_pop     (pop),
        .i_a       (q_a),
        .i_den     (q_den),
        .i_ctl     (q_ctl),
        .o_valid   (o_col.valid),
        .i_ready   (o_col.ready),
        .o_red     (o_col.red_level),
        .o_green   (o_col.green_level),
        .o_blue    (o_col.blue_level),
        .o_invalid (o_col.invalid_request)
    );

endmodule
`default_nettype wire

@@ src/crg_front.sv @@
// Front end: configuration registers, request classification and hue sector divide.
`timescale 1ns / 1ps
`default_nettype none
module crg_front
    import crg_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  wire logic [cfg_width(INDEX_BITS)-1:0]    i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [INDEX_BITS-1:0]               i_index,
    output logic                                     o_push,
    input  wire logic                                i_full,
    output logic [arg_width(INDEX_BITS)-1:0]         o_a,
    output logic [arg_width(INDEX_BITS)-1:0]         o_den,
    output t_job_ctl                                 o_ctl
);

    localparam int NW  = size_width(INDEX_BITS);
    localparam int AW  = arg_width(INDEX_BITS);
    localparam int HW  = NW + HUE_QBITS;
    localparam int TW  = NW + 5;
    localparam int LST = HUE_QBITS;

    logic [PRESET_W-1:0]   r_preset;
    logic [INDEX_BITS-1:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset <= PRESET_W'(PRESET_RESET);
            r_size   <= INDEX_BITS'(SIZE_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PRESET: r_preset <= i_cfg_data[PRESET_W-1:0];
                REG_SIZE:   r_size   <= i_cfg_data[INDEX_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // Classification of the incoming transaction
    logic [NW-1:0] n_eff, d_eff, half, first, idx;
    logic [TW-1:0] n3, n7, n10, i14, t_seg, t_ofs;
    logic [HW-1:0] s_hnum;
    logic [AW-1:0] s_a;
    logic          s_hue, s_bad;
    t_map          s_map;
    t_src          lead_src, rest_src;

    always_comb begin
        n_eff    = (r_size < INDEX_BITS'(2)) ? NW'(SIZE_RESET) : NW'(r_size);
        d_eff    = n_eff - NW'(1);
        half     = n_eff >> 1;
        first    = n_eff - half;
        idx      = NW'(i_index);
        n3       = (TW'(n_eff) << 1) + TW'(n_eff);
        n7       = (TW'(n_eff) << 3) - TW'(n_eff);
        n10      = (TW'(n_eff) << 3) + (TW'(n_eff) << 1);
        i14      = (TW'(idx) << 4) - (TW'(idx) << 1);
        t_seg    = '0;
        t_ofs    = '0;
        s_bad    = (idx >= n_eff) || (r_preset > PR_HSV);
        s_hue    = 1'b0;
        s_hnum   = '0;
        s_a      = AW'(idx);
        lead_src = SRC_ZERO;
        rest_src = SRC_ZERO;
        s_map    = '{SRC_ZERO, SRC_ZERO, SRC_ZERO};

        // Dark-first and inverse two-segment numerators over 10N
        if (r_preset == PR_RED || r_preset == PR_GREEN || r_preset == PR_BLUE) begin
            if (idx < half) begin
                t_seg    = n3 + i14;
                lead_src = SRC_UP;
                rest_src = SRC_ZERO;
            end else begin
                t_ofs    = TW'(idx - half);
                t_seg    = (t_ofs << 4) - (t_ofs << 1);
                lead_src = SRC_FULL;
                rest_src = SRC_UP;
            end
            s_a = (t_seg > n10) ? AW'(n10) : AW'(t_seg);
        end else begin
            if (idx < first) begin
                t_seg    = (n7 >= i14) ? (n7 - i14) : '0;
                lead_src = SRC_FULL;
                rest_src = SRC_UP;
            end else begin
                t_ofs    = TW'(idx - first);
                t_ofs    = (t_ofs << 4) - (t_ofs << 1);
                t_seg    = (n10 >= t_ofs) ? (n10 - t_ofs) : '0;
                lead_src = SRC_UP;
                rest_src = SRC_ZERO;
            end
            if (r_preset > PR_BLUE_TO_CYAN) begin
                s_a = AW'(t_seg);
            end
        end

        unique case (r_preset) inside
            PR_RED_TO_BLUE: begin
                s_hue  = 1'b1;
                s_hnum = HW'(idx) << 2;
            end
            PR_BLUE_TO_RED: begin
                s_hue  = 1'b1;
                s_hnum = (HW'(d_eff) - HW'(idx)) << 2;
            end
            PR_YELLOW_TO_CYAN: begin
                s_hue  = 1'b1;
                s_hnum = (HW'(idx) << 1) + HW'(d_eff);
            end
            PR_CYAN_TO_YELLOW: begin
                s_hue  = 1'b1;
                s_hnum = (HW'(d_eff) << 1) + HW'(d_eff) - (HW'(idx) << 1);
            end
            PR_HSV: begin
                s_hue  = 1'b1;
                s_hnum = (HW'(idx) << 2) + (HW'(idx) << 1);
            end
            PR_RED_TO_YELLOW:   s_map = '{SRC_FULL, SRC_UP, SRC_ZERO};
            PR_YELLOW_TO_RED:   s_map = '{SRC_FULL, SRC_DN, SRC_ZERO};
            PR_YELLOW_TO_GREEN: s_map = '{SRC_DN, SRC_FULL, SRC_ZERO};
            PR_GREEN_TO_YELLOW: s_map = '{SRC_UP, SRC_FULL, SRC_ZERO};
            PR_GREEN_TO_CYAN:   s_map = '{SRC_ZERO, SRC_FULL, SRC_UP};
            PR_CYAN_TO_GREEN:   s_map = '{SRC_ZERO, SRC_FULL, SRC_DN};
            PR_CYAN_TO_BLUE:    s_map = '{SRC_ZERO, SRC_DN, SRC_FULL};
            PR_BLUE_TO_CYAN:    s_map = '{SRC_ZERO, SRC_UP, SRC_FULL};
            PR_RED, PR_RED_INV:     s_map = '{lead_src, rest_src, rest_src};
            PR_GREEN, PR_GREEN_INV: s_map = '{rest_src, lead_src, rest_src};
            PR_BLUE, PR_BLUE_INV:   s_map = '{rest_src, rest_src, lead_src};
            default:            s_map = '{SRC_ZERO, SRC_ZERO, SRC_ZERO};
        endcase
    end

    // Pipeline: stage 0 holds the classified transaction, stages 1..3 resolve the sector
    logic          r_fv   [0:LST];
    logic          r_hue  [0:LST];
    logic          r_inv  [0:LST];
    logic [HW-1:0] r_hr   [0:LST];
    logic [HUE_QBITS-1:0] r_hq [0:LST];
    logic [NW-1:0] r_d    [0:LST];
    logic [AW-1:0] r_a    [0:LST];
    logic [AW-1:0] r_den  [0:LST];
    t_map          r_map  [0:LST];
    logic          adv    [0:LST+1];

    assign adv[LST+1] = !i_full;
    assign o_ready    = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv[0] <= 1'b0;
        end else if (adv[0]) begin
            r_fv[0] <= i_valid;
        end
        if (adv[0]) begin
            r_hue[0] <= s_hue;
            r_inv[0] <= s_bad;
            r_hr[0]  <= s_hnum;
            r_hq[0]  <= '0;
            r_d[0]   <= d_eff;
            r_a[0]   <= s_a;
            r_den[0] <= s_hue ? AW'(d_eff) :
                        ((r_preset > PR_BLUE_TO_CYAN) ? AW'(n10) : AW'(n_eff));
            r_map[0] <= s_map;
        end
    end

    for (genvar k = 0; k <= LST; k++) begin : g_adv
        assign adv[k] = !r_fv[k] || adv[k+1];
    end

    for (genvar k = 1; k <= LST; k++) begin : g_hdiv
        localparam int B = LST - k;
        logic [HW-1:0] dd;
        logic          ge;
        assign dd = HW'(r_d[k-1]) << B;
        assign ge = (r_hr[k-1] >= dd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fv[k] <= 1'b0;
            end else if (adv[k]) begin
                r_fv[k] <= r_fv[k-1];
            end
            if (adv[k]) begin
                r_hue[k] <= r_hue[k-1];
                r_inv[k] <= r_inv[k-1];
                r_hr[k]  <= ge ? (r_hr[k-1] - dd) : r_hr[k-1];
                r_hq[k]  <= r_hq[k-1] | (ge ? HUE_QBITS'(1 << B) : '0);
                r_d[k]   <= r_d[k-1];
                r_a[k]   <= r_a[k-1];
                r_den[k] <= r_den[k-1];
                r_map[k] <= r_map[k-1];
            end
        end
    end

    assign o_push          = r_fv[LST] && !i_full;
    assign o_a             = r_hue[LST] ? AW'(r_hr[LST]) : r_a[LST];
    assign o_den           = r_den[LST];
    assign o_ctl.invalid   = r_inv[LST];
    assign o_ctl.map       = r_hue[LST] ? hue_map(r_hq[LST]) : r_map[LST];

endmodule
`default_nettype wire

@@ src/crg_queue.sv @@
// Short job queue between the front end and the rounding divider.
`timescale 1ns / 1ps
`default_nettype none
module crg_queue
    import crg_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire logic [arg_width(INDEX_BITS)-1:0]  i_a,
    input  wire logic [arg_width(INDEX_BITS)-1:0]  i_den,
    input  wire t_job_ctl                          i_ctl,
    output logic                                   o_full,
    output logic                                   o_valid,
    input  wire logic                              i_pop,
    output logic [arg_width(INDEX_BITS)-1:0]       o_a,
    output logic [arg_width(INDEX_BITS)-1:0]       o_den,
    output t_job_ctl                               o_ctl
);

    localparam int AW  = arg_width(INDEX_BITS);
    localparam int QAW = $clog2(QUEUE_DEPTH);

    logic [AW-1:0] r_mem_a   [QUEUE_DEPTH];
    logic [AW-1:0] r_mem_den [QUEUE_DEPTH];
    t_job_ctl      r_mem_ctl [QUEUE_DEPTH];
    logic [QAW:0]  r_wp, r_rp;

    assign o_full  = (r_wp[QAW] != r_rp[QAW]) && (r_wp[QAW-1:0] == r_rp[QAW-1:0]);
    assign o_valid = (r_wp != r_rp);
    assign o_a     = r_mem_a[r_rp[QAW-1:0]];
    assign o_den   = r_mem_den[r_rp[QAW-1:0]];
    assign o_ctl   = r_mem_ctl[r_rp[QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + (QAW+1)'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + (QAW+1)'(1);
            end
        end
        if (i_push) begin
            r_mem_a[r_wp[QAW-1:0]]   <= i_a;
            r_mem_den[r_wp[QAW-1:0]] <= i_den;
            r_mem_ctl[r_wp[QAW-1:0]] <= i_ctl;
        end
    end

endmodule
`default_nettype wire

@@ src/crg_back.sv @@
// Back end: pipelined rounding divider and channel assembly into the output register.
`timescale 1ns / 1ps
`default_nettype none
module crg_back
    import crg_pkg::*;
#(
    parameter int INDEX_BITS   = DEF_INDEX_BITS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_pop,
    input  wire logic [arg_width(INDEX_BITS)-1:0]  i_a,
    input  wire logic [arg_width(INDEX_BITS)-1:0]  i_den,
    input  wire t_job_ctl                          i_ctl,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [CHANNEL_BITS-1:0]                o_red,
    output logic [CHANNEL_BITS-1:0]                o_green,
    output logic [CHANNEL_BITS-1:0]                o_blue,
    output logic                                   o_invalid
);

    localparam int AW = arg_width(INDEX_BITS);
    localparam int CB = CHANNEL_BITS;
    localparam int XW = AW + CB + 1;
    localparam int DW = AW + 1;

    logic          r_bv  [0:CB];
    logic [XW-1:0] r_x   [0:CB];
    logic [DW-1:0] r_dv  [0:CB];
    logic [CB-1:0] r_y   [0:CB];
    t_job_ctl      r_ctl [0:CB];
    logic          adv   [0:CB+1];

    logic                r_ov;
    logic [CB-1:0]       r_red, r_green, r_blue;
    logic                r_inv;

    assign adv[CB+1] = !r_ov || i_ready;
    assign o_pop     = i_valid && adv[0];

    for (genvar k = 0; k <= CB; k++) begin : g_adv
        assign adv[k] = !r_bv[k] || adv[k+1];
    end

    // Load round(a * full / den) as floor((2*a*full + den) / (2*den))
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv[0] <= 1'b0;
        end else if (adv[0]) begin
            r_bv[0] <= i_valid;
        end
        if (adv[0]) begin
            r_x[0]   <= (XW'(i_a) << (CB + 1)) - (XW'(i_a) << 1) + XW'(i_den);
            r_dv[0]  <= DW'(i_den) << 1;
            r_y[0]   <= '0;
            r_ctl[0] <= i_ctl;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= CB; k++) begin : g_div
        localparam int B = CB - k;
        logic [XW-1:0] dd;
        logic          ge;
        assign dd = XW'(r_dv[k-1]) << B;
        assign ge = (r_x[k-1] >= dd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bv[k] <= 1'b0;
            end else if (adv[k]) begin
                r_bv[k] <= r_bv[k-1];
            end
            if (adv[k]) begin
                r_x[k]   <= ge ? (r_x[k-1] - dd) : r_x[k-1];
                r_dv[k]  <= r_dv[k-1];
                r_y[k]   <= r_y[k-1] | (ge ? CB'(1 << B) : '0);
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // The complementary level is full - y, plus one when the division was exact
    logic [CB-1:0] up_lvl, dn_lvl;
    assign up_lvl = r_y[CB];
    assign dn_lvl = {CB{1'b1}} - up_lvl + CB'(r_x[CB] == '0);

    function automatic logic [CB-1:0] pick(t_src s, logic [CB-1:0] up, logic [CB-1:0] dn);
        logic [CB-1:0] v;
        v = '0;
        case (s)
            SRC_FULL: v = {CB{1'b1}};
            SRC_UP:   v = up;
            SRC_DN:   v = dn;
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv[CB+1]) begin
            r_ov <= r_bv[CB];
        end
        if (adv[CB+1]) begin
            r_inv <= r_ctl[CB].invalid;
            if (r_ctl[CB].invalid) begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end else begin
                r_red   <= pick(r_ctl[CB].map.red, up_lvl, dn_lvl);
                r_green <= pick(r_ctl[CB].map.green, up_lvl, dn_lvl);
                r_blue  <= pick(r_ctl[CB].map.blue, up_lvl, dn_lvl);
            end
        end
    end

    assign o_valid   = r_ov;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_invalid = r_inv;

endmodule
`default_nettype wire

@@ dv/crg_checker.sv @@
// Checker for the preset color ramp generator: predicts colors and compares results.
`timescale 1ns / 1ps
`default_nettype none
module crg_checker
    import crg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    crg_index_if                      pix,
    crg_color_if                      col,
    output int                        o_fail_count,
    output int                        o_pending
);
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        invalid;
    } t_color;

    localparam longint FULL = 65535;

    logic [PRESET_W-1:0] preset;
    logic [15:0]         size_reg;
    t_color              expected_colors[$];

    function automatic longint scale_level(longint num, longint den);
        if (den == 0) return 0;
        if (num < 0) num = 0;
        if (num > den) num = den;
        return (2 * num * FULL + den) / (2 * den);
    endfunction

    function automatic void hue_color(longint num, longint den, ref longint rgb[3]);
        longint sec, up, dn;
        sec = (num / den) % 6;
        up  = scale_level(num % den, den);
        dn  = scale_level(den - num % den, den);
        case (sec)
            0: rgb = '{FULL, up, 0};
            1: rgb = '{dn, FULL, 0};
            2: rgb = '{0, FULL, up};
            3: rgb = '{0, dn, FULL};
            4: rgb = '{up, 0, FULL};
            default: rgb = '{FULL, 0, dn};
        endcase
    endfunction

    function automatic t_color predict_color(logic [15:0] idx);
        t_color c;
        longint n, i, d, half, first, up, dn, bright, ramp, lead, fade;
        longint rgb[3];
        n = (size_reg < 2) ? 256 : size_reg;
        i = idx;
        c = '0;
        if (i >= n || preset > PR_HSV) begin
            c.invalid = 1'b1;
            return c;
        end
        d = n - 1;
        half = n / 2;
        first = n - half;
        up = scale_level(i, n);
        dn = scale_level(n - i, n);
        if (i < half) begin
            bright = scale_level(3 * n + 14 * i, 10 * n);
            ramp = 0;
        end else begin
            bright = FULL;
            ramp = scale_level(14 * (i - half), 10 * n);
        end
        if (i < first) begin
            lead = FULL;
            fade = scale_level(7 * n - 14 * i, 10 * n);
        end else begin
            lead = scale_level(10 * n - 14 * (i - first), 10 * n);
            fade = 0;
        end
        rgb = '{0, 0, 0};
        case (preset)
            PR_RED_TO_BLUE:     hue_color(4 * i, d, rgb);
            PR_BLUE_TO_RED:     hue_color(4 * (d - i), d, rgb);
            PR_YELLOW_TO_CYAN:  hue_color(2 * i + d, d, rgb);
            PR_CYAN_TO_YELLOW:  hue_color(3 * d - 2 * i, d, rgb);
            PR_RED_TO_YELLOW:   rgb = '{FULL, up, 0};
            PR_YELLOW_TO_RED:   rgb = '{FULL, dn, 0};
            PR_YELLOW_TO_GREEN: rgb = '{dn, FULL, 0};
            PR_GREEN_TO_YELLOW: rgb = '{up, FULL, 0};
            PR_GREEN_TO_CYAN:   rgb = '{0, FULL, up};
            PR_CYAN_TO_GREEN:   rgb = '{0, FULL, dn};
            PR_CYAN_TO_BLUE:    rgb = '{0, dn, FULL};
            PR_BLUE_TO_CYAN:    rgb = '{0, up, FULL};
            PR_RED:             rgb = '{bright, ramp, ramp};
            PR_GREEN:           rgb = '{ramp, bright, ramp};
            PR_BLUE:            rgb = '{ramp, ramp, bright};
            PR_RED_INV:         rgb = '{lead, fade, fade};
            PR_GREEN_INV:       rgb = '{fade, lead, fade};
            PR_BLUE_INV:        rgb = '{fade, fade, lead};
            default:            hue_color(6 * i, d, rgb);
        endcase
        c.red = rgb[0][15:0];
        c.green = rgb[1][15:0];
        c.blue = rgb[2][15:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_color want;
        int     errs;
        int     pushed;
        int     popped;
        errs = 0;
        pushed = 0;
        popped = 0;
        if (!i_rst_n) begin
            preset <= PRESET_W'(PRESET_RESET);
            size_reg <= 16'(SIZE_RESET);
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_PRESET) preset <= i_cfg_data[PRESET_W-1:0];
            if (i_cfg_we && i_cfg_index == REG_SIZE) size_reg <= i_cfg_data;
            if (pix.valid && pix.ready) begin
                expected_colors.insert(expected_colors.size(),
                                       predict_color(pix.entry_index));
                pushed = 1;
            end
            if (col.valid && col.ready) begin
                if (expected_colors.size() == 0) begin
                    $error("color result with no request outstanding");
                    errs++;
                end else begin
                    want = expected_colors.pop_front();
                    popped = 1;
                    if (col.red_level !== want.red) begin
                        $error("red_level expected %0d got %0d", want.red, col.red_level);
                        errs++;
                    end
                    if (col.green_level !== want.green) begin
                        $error("green_level expected %0d got %0d", want.green, col.green_level);
                        errs++;
                    end
                    if (col.blue_level !== want.blue) begin
                        $error("blue_level expected %0d got %0d", want.blue, col.blue_level);
                        errs++;
                    end
                    if (col.invalid_request !== want.invalid) begin
                        $error("invalid_request expected %0d got %0d", want.invalid,
                               col.invalid_request);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= o_pending + pushed - popped;
        end
    end
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench top: drives palette indexes and configuration, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import crg_pkg::*;

    localparam int LATENCY = 40;
    localparam int STALL_LIMIT = 4000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PRESET;
    logic [15:0]          cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    bit                   hold_long = 1'b0;

    crg_index_if pix ();
    crg_color_if col ();

    preset_color_ramp_generator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .i_pix(pix), .o_col(col)
    );

    crg_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .pix(pix), .col(col),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        pix.valid = 1'b0;
        pix.entry_index = '0;
        col.ready = 1'b0;
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (col.valid && col.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin : sink_proc
        int gap;
        int j;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                col.ready <= 1'b0;
                for (j = 0; j < 200; j++) @(posedge i_clk);
                hold_long = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                col.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            col.ready <= 1'b1;
            @(posedge i_clk iff col.valid);
        end
    end

    task automatic send_index(logic [15:0] idx, int gap);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.entry_index <= idx;
        @(posedge i_clk iff pix.ready);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_gap(bit dense);
        if (dense) return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 3));
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(2, 300));
        endcase
    endfunction

    initial begin : stim
        logic [15:0] sz;
        int n;
        int p;
        int k;
        bit dense;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: reset settings, edges of the index field
        send_index(16'd0, 0);
        send_index(16'd255, 0);
        send_index(16'd256, 0);
        send_index(16'hFFFF, 0);
        send_index(16'd128, 1);
        drain();
        write_reg(REG_SIZE, 16'hFFFF);
        write_reg(REG_PRESET, 16'(PR_RED_TO_BLUE));
        send_index(16'hFFFE, 0);
        send_index(16'hFFFF, 0);
        send_index(16'h5555, 0);
        send_index(16'hAAAA, 0);
        drain();
        write_reg(REG_SIZE, 16'd1);
        write_reg(REG_PRESET, 16'd31);
        send_index(16'd0, 0);
        send_index(16'd255, 0);
        drain();
        write_reg(REG_SIZE, 16'd0);
        write_reg(REG_PRESET, 16'(PR_BLUE_INV));
        send_index(16'd0, 0);
        send_index(16'd128, 0);
        send_index(16'd255, 0);
        drain();
        write_reg(REG_SIZE, 16'd2);
        write_reg(REG_PRESET, 16'(PR_RED));
        send_index(16'd0, 0);
        send_index(16'd1, 0);
        send_index(16'd2, 0);
        drain();
        write_reg(REG_SIZE, 16'd7);
        write_reg(REG_PRESET, 16'(PR_HSV));
        for (k = 0; k < 7; k++) send_index(16'(k), 0);
        drain();
        // random phases: each picks a random preset with a fresh size
        for (p = 0; p < 40; p++) begin
            sz = pick_size();
            write_reg(REG_SIZE, sz);
            write_reg(REG_PRESET, ($urandom_range(0, 9) == 0) ?
                      16'($urandom_range(19, 31)) : 16'($urandom_range(0, 18)));
            n = (sz < 2) ? 256 : sz;
            dense = ($urandom_range(0, 2) == 0);
            // keep offering back to back while the receiver holds off
            if (p == 5) begin
                hold_long = 1'b1;
                dense = 1'b1;
            end
            for (k = 0; k < 40; k++) begin
                case ($urandom_range(0, 9))
                    0: send_index(16'($urandom_range(0, 65535)), pick_gap(dense));
                    1: send_index(16'(n - 1), pick_gap(dense));
                    2: send_index(16'(n / 2 + $urandom_range(0, 1) - 1), pick_gap(dense));
                    default: send_index(16'($urandom_range(0, n - 1)), pick_gap(dense));
                endcase
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
